// File: rtl/sbtf_pkg.sv
`default_nettype none

package sbtf_pkg;

    localparam int OUT_BITS        = 40;
    localparam int BAND_REG_BITS   = 4;
    localparam int CFG_DATA_BITS   = 64;
    localparam int CFG_IDX_BITS    = 2;

    localparam int DEF_MAX_BAND    = 8;
    localparam int DEF_SAMPLE_BITS = 16;
    localparam int DEF_COEF_BITS   = 16;

    localparam logic [BAND_REG_BITS-1:0] BAND_RESET = BAND_REG_BITS'(1);

    localparam logic [CFG_IDX_BITS-1:0] CFG_BAND    = CFG_IDX_BITS'(0);
    localparam logic [CFG_IDX_BITS-1:0] CFG_COEF_LO = CFG_IDX_BITS'(1);
    localparam logic [CFG_IDX_BITS-1:0] CFG_COEF_HI = CFG_IDX_BITS'(2);

    typedef struct packed {
        logic shift;
        logic load;
    } t_cell_ctrl;

endpackage

`default_nettype wire

// File: rtl/sbtf_cell.sv
`default_nettype none

module sbtf_cell #(
    parameter int MAX_BAND    = sbtf_pkg::DEF_MAX_BAND,
    parameter int SAMPLE_BITS = sbtf_pkg::DEF_SAMPLE_BITS,
    parameter int COEF_BITS   = sbtf_pkg::DEF_COEF_BITS,
    parameter int TAP         = 0
) (
    input  wire                                   i_clk,
    input  wire                                   i_rst_n,
    input  wire sbtf_pkg::t_cell_ctrl             i_ctrl,
    input  wire logic signed [SAMPLE_BITS-1:0]    i_sample,
    input  wire logic [$clog2(2*MAX_BAND)-1:0]    i_lbm1,
    input  wire logic [$clog2(2*MAX_BAND)-1:0]    i_need,
    input  wire logic [MAX_BAND*COEF_BITS-1:0]    i_coefs,
    output logic signed [SAMPLE_BITS-1:0]         o_sample,
    output logic signed [SAMPLE_BITS+COEF_BITS-1:0] o_product
);

    localparam int D_W   = $clog2(2*MAX_BAND);
    localparam int IDX_W = (MAX_BAND > 1) ? $clog2(MAX_BAND) : 1;
    localparam logic [D_W-1:0] POS = D_W'(TAP);

    logic signed [SAMPLE_BITS-1:0]           r_sample;
    logic signed [SAMPLE_BITS+COEF_BITS-1:0] r_product;
    logic [D_W-1:0]                          tap_off;
    logic [IDX_W-1:0]                        idx;
    logic signed [COEF_BITS-1:0]             tap_coef;

    // distance from the diagonal, zero tap outside the band
    always_comb begin
        tap_off = (POS >= i_lbm1) ? (POS - i_lbm1) : (i_lbm1 - POS);
        idx     = tap_off[IDX_W-1:0];
        if (POS >= i_need) begin
            tap_coef = '0;
        end else begin
            tap_coef = signed'(i_coefs[idx*COEF_BITS +: COEF_BITS]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sample <= '0;
        end else if (i_ctrl.shift) begin
            r_sample <= i_sample;
        end
        if (i_ctrl.load) begin
            r_product <= r_sample * tap_coef;
        end
    end

    assign o_sample  = r_sample;
    assign o_product = r_product;

endmodule

`default_nettype wire

// File: rtl/symmetric_band_toeplitz_filter_core.sv
// Throughput: one sample per cycle while i_m_tready is not holding back a full
// pipeline; the stages are the cell row, where every cell shifts its sample and
// registers one product per cycle, then a partial-sum register and the output
// register.
// Reset (i_rst_n low, synchronous): pipeline emptied, sample window and count
// cleared, band 1, coefficients zero. No clearing pass.
`default_nettype none

module symmetric_band_toeplitz_filter_core #(
    parameter int MAX_BAND    = sbtf_pkg::DEF_MAX_BAND,
    parameter int SAMPLE_BITS = sbtf_pkg::DEF_SAMPLE_BITS,
    parameter int COEF_BITS   = sbtf_pkg::DEF_COEF_BITS
) (
    input  wire                                       i_clk,
    input  wire                                       i_rst_n,
    // slave side
    input  wire                                       i_s_tvalid,
    output logic                                      o_s_tready,
    input  wire [((SAMPLE_BITS+7)/8)*8-1:0]           i_s_tdata,  // sample
    input  wire                                       i_s_tlast,  // last_in_column
    // master side
    output logic                                      o_m_tvalid,
    input  wire                                       i_m_tready,
    output logic [sbtf_pkg::OUT_BITS-1:0]             o_m_tdata,  // filtered_value
    output logic                                      o_m_tlast,  // last_result
    // configuration
    input  wire                                       i_cfg_we,
    input  wire [sbtf_pkg::CFG_IDX_BITS-1:0]          i_cfg_idx,
    input  wire [sbtf_pkg::CFG_DATA_BITS-1:0]         i_cfg_data
);

    localparam int W      = 2*MAX_BAND - 1;
    localparam int D_W    = $clog2(2*MAX_BAND);
    localparam int LB_W   = $clog2(MAX_BAND + 1);
    localparam int P_W    = SAMPLE_BITS + COEF_BITS;
    localparam int ACC_W  = sbtf_pkg::OUT_BITS;
    localparam int NG     = (W + 3) / 4;
    localparam int CW     = MAX_BAND * COEF_BITS;
    localparam int BW     = sbtf_pkg::BAND_REG_BITS;

    logic [BW-1:0]                             r_band;
    logic [sbtf_pkg::CFG_DATA_BITS-1:0]        r_coef_lo;
    logic [sbtf_pkg::CFG_DATA_BITS-1:0]        r_coef_hi;
    logic [D_W-1:0]                            r_cnt;
    logic                                      r_v0, r_v1, r_v2, r_v3;
    logic                                      r_last0, r_last1, r_last2, r_last3;
    logic signed [ACC_W-1:0]                   r_part [NG];
    logic signed [ACC_W-1:0]                   r_sum;

    logic [LB_W-1:0]                           lb;
    logic [D_W-1:0]                            lbm1;
    logic [D_W-1:0]                            need;
    logic [D_W-1:0]                            cnt_new;
    logic                                      has_res;
    logic                                      accept;
    logic                                      rdy0, rdy1, rdy2, rdy3;
    logic [CW-1:0]                             coefs;
    sbtf_pkg::t_cell_ctrl                      ctrl;
    logic signed [SAMPLE_BITS-1:0]             chain [W+1];
    logic signed [P_W-1:0]                     prod [W];
    logic signed [ACC_W-1:0]                   ext_p [NG*4];
    logic signed [ACC_W-1:0]                   n_part [NG];
    logic signed [ACC_W-1:0]                   n_sum;

    always_comb begin
        if (r_band == '0) begin
            lb = LB_W'(1);
        end else if (int'(r_band) > MAX_BAND) begin
            lb = LB_W'(MAX_BAND);
        end else begin
            lb = LB_W'(r_band);
        end
        lbm1    = D_W'(lb) - D_W'(1);
        need    = (D_W'(lb) << 1) - D_W'(1);
        cnt_new = (r_cnt == D_W'(W)) ? r_cnt : r_cnt + D_W'(1);
        has_res = (cnt_new >= need);
    end

    assign coefs = CW'({r_coef_hi, r_coef_lo});

    assign rdy3   = !r_v3 || i_m_tready;
    assign rdy2   = !r_v2 || rdy3;
    assign rdy1   = !r_v1 || rdy2;
    assign rdy0   = !r_v0 || rdy1;
    assign accept = i_s_tvalid && rdy0;

    assign ctrl.shift = accept;
    assign ctrl.load  = rdy1;

    assign chain[0] = signed'(i_s_tdata[SAMPLE_BITS-1:0]);

    for (genvar k = 0; k < W; k++) begin : g_cell
        sbtf_cell #(
            .MAX_BAND    (MAX_BAND),
            .SAMPLE_BITS (SAMPLE_BITS),
            .COEF_BITS   (COEF_BITS),
            .TAP         (k)
        ) u_cell (
            .i_clk     (i_clk),
            .i_rst_n   (i_rst_n),
            .i_ctrl    (ctrl),
            .i_sample  (chain[k]),
            .i_lbm1    (lbm1),
            .i_need    (need),
            .i_coefs   (coefs),
            .o_sample  (chain[k+1]),
            .o_product (prod[k])
        );
    end

    for (genvar k = 0; k < NG*4; k++) begin : g_ext
        if (k < W) begin : g_tap
            assign ext_p[k] = ACC_W'(prod[k]);
        end else begin : g_pad
            assign ext_p[k] = '0;
        end
    end

    always_comb begin
        for (int g = 0; g < NG; g++) begin
            n_part[g] = ext_p[4*g] + ext_p[4*g+1] + ext_p[4*g+2] + ext_p[4*g+3];
        end
        n_sum = '0;
        for (int g = 0; g < NG; g++) begin
            n_sum = n_sum + r_part[g];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_band    <= sbtf_pkg::BAND_RESET;
            r_coef_lo <= '0;
            r_coef_hi <= '0;
            r_cnt     <= '0;
            r_v0      <= 1'b0;
            r_v1      <= 1'b0;
            r_v2      <= 1'b0;
            r_v3      <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    sbtf_pkg::CFG_BAND:    r_band    <= i_cfg_data[BW-1:0];
                    sbtf_pkg::CFG_COEF_LO: r_coef_lo <= i_cfg_data;
                    sbtf_pkg::CFG_COEF_HI: r_coef_hi <= i_cfg_data;
                    default: ;
                endcase
            end
            if (accept) begin
                r_cnt <= i_s_tlast ? '0 : cnt_new;
            end
            if (rdy0) begin
                r_v0 <= accept && has_res;
            end
            if (rdy1) begin
                r_v1 <= r_v0;
            end
            if (rdy2) begin
                r_v2 <= r_v1;
            end
            if (rdy3) begin
                r_v3 <= r_v2;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (rdy0) begin
            r_last0 <= i_s_tlast;
        end
        if (rdy1) begin
            r_last1 <= r_last0;
        end
        if (rdy2) begin
            r_last2 <= r_last1;
            r_part  <= n_part;
        end
        if (rdy3) begin
            r_last3 <= r_last2;
            r_sum   <= n_sum;
        end
    end

    assign o_s_tready = rdy0;
    assign o_m_tvalid = r_v3;
    assign o_m_tdata  = r_sum;
    assign o_m_tlast  = r_last3;

    a_out_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_v3 && !i_m_tready |=> r_v3)
        else $error("pending result lost");

    a_stage2_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_v2 && r_v3 && !i_m_tready |=> r_v2 && $stable(r_last2))
        else $error("partial sum stage overwritten while stalled");

    a_stall_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_s_tready |-> r_v0 && r_v1 && r_v2 && r_v3)
        else $error("input stalled with a free stage");

    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        int'(r_cnt) <= W)
        else $error("sample count beyond window depth");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_tvalid)
        else $error("result valid after reset");

endmodule

`default_nettype wire

// File: tb/symmetric_band_toeplitz_filter_core_tb.sv
module symmetric_band_toeplitz_filter_core_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int OUT_BITS        = sbtf_pkg::OUT_BITS;
    localparam int DEF_MAX_BAND    = sbtf_pkg::DEF_MAX_BAND;
    localparam int DEF_SAMPLE_BITS = sbtf_pkg::DEF_SAMPLE_BITS;
    localparam int DEF_COEF_BITS   = sbtf_pkg::DEF_COEF_BITS;
    localparam int BAND_REG_BITS   = sbtf_pkg::BAND_REG_BITS;
    localparam int CFG_IDX_BITS    = sbtf_pkg::CFG_IDX_BITS;
    localparam int CFG_DATA_BITS   = sbtf_pkg::CFG_DATA_BITS;

    localparam int WIN_DEPTH     = 2 * DEF_MAX_BAND - 1;
    localparam int IDLE_LIMIT    = 5000;
    localparam int SETTLE_CYCLES = 8;
    localparam int RANDOM_PHASES = 12;
    localparam int PHASE_ITEMS   = 46;
    localparam int MAX_REPORTS   = 10;
    localparam int BAND_PLAN [6] = '{8, 0, 15, 1, 9, 2};

    typedef struct {
        logic [OUT_BITS-1:0] value;
        logic                last;
    } t_band_sum;

    // Predicts band sums from accepted samples and checks them in order
    class band_sum_scoreboard;
        logic signed [DEF_SAMPLE_BITS-1:0] window [WIN_DEPTH];
        int                                seen;
        logic [BAND_REG_BITS-1:0]          band;
        logic [2*CFG_DATA_BITS-1:0]        coefs;
        t_band_sum                         pending_sums [$];
        int                                mismatches;
        int                                checked;
        int                                last_marks;

        function new();
            foreach (window[i]) window[i] = '0;
            seen       = 0;
            band       = sbtf_pkg::BAND_RESET;
            coefs      = '0;
            mismatches = 0;
            checked    = 0;
            last_marks = 0;
        endfunction

        function int effective_band();
            if (band == 0) return 1;
            if (band > DEF_MAX_BAND) return DEF_MAX_BAND;
            return int'(band);
        endfunction

        function void set_reg(logic [CFG_IDX_BITS-1:0] idx, logic [CFG_DATA_BITS-1:0] data);
            case (idx)
                sbtf_pkg::CFG_BAND:    band = data[BAND_REG_BITS-1:0];
                sbtf_pkg::CFG_COEF_LO: coefs[CFG_DATA_BITS-1:0] = data;
                sbtf_pkg::CFG_COEF_HI: coefs[2*CFG_DATA_BITS-1:CFG_DATA_BITS] = data;
                default: ;
            endcase
        endfunction

        function void note_sample(logic [DEF_SAMPLE_BITS-1:0] smp, logic last);
            int                               lb;
            int                               need;
            int                               offs;
            longint                           acc;
            logic signed [DEF_COEF_BITS-1:0]  c;
            t_band_sum                        due;
            lb   = effective_band();
            need = 2 * lb - 1;
            for (int d = WIN_DEPTH - 1; d > 0; d--) window[d] = window[d-1];
            window[0] = smp;
            if (seen < WIN_DEPTH) seen++;
            if (seen >= need) begin
                acc = 0;
                for (int d = 0; d < need; d++) begin
                    offs = (d >= lb - 1) ? d - (lb - 1) : (lb - 1) - d;
                    c    = coefs[offs*DEF_COEF_BITS +: DEF_COEF_BITS];
                    acc += longint'(c) * longint'(window[d]);
                end
                due.value = acc[OUT_BITS-1:0];
                due.last  = last;
                pending_sums.push_back(due);
            end
            // column closed: window restarts empty
            if (last) begin
                foreach (window[i]) window[i] = '0;
                seen = 0;
            end
        endfunction

        function void check_result(logic [OUT_BITS-1:0] value, logic last);
            t_band_sum due;
            if (pending_sums.size() == 0) begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display("ERROR: band sum %h (last %b) with nothing outstanding",
                             value, last);
                return;
            end
            due = pending_sums.pop_front();
            checked++;
            if (value !== due.value) begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display("ERROR: band sum #%0d: expected %h, got %h",
                             checked, due.value, value);
            end
            if (last !== due.last) begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display("ERROR: last flag of band sum #%0d: expected %b, got %b",
                             checked, due.last, last);
            end
            if (last === 1'b1) last_marks++;
        endfunction
    endclass

    logic                        i_clk = 1'b0;
    logic                        i_rst_n;
    logic                        i_s_tvalid;
    logic                        o_s_tready;
    logic [15:0]                 i_s_tdata;
    logic                        i_s_tlast;
    logic                        o_m_tvalid;
    logic                        i_m_tready;
    logic [OUT_BITS-1:0]         o_m_tdata;
    logic                        o_m_tlast;
    logic                        i_cfg_we;
    logic [CFG_IDX_BITS-1:0]     i_cfg_idx;
    logic [CFG_DATA_BITS-1:0]    i_cfg_data;

    band_sum_scoreboard sb;
    int send_idle_pct = 0;
    int stall_pct     = 0;
    int idle_cycles   = 0;
    int col_left      = 0;
    int sent          = 0;
    int columns       = 0;

    symmetric_band_toeplitz_filter_core u_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),   // sample
        .i_s_tlast  (i_s_tlast),   // last_in_column
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),   // filtered_value
        .o_m_tlast  (o_m_tlast),   // last_result
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    always #1 i_clk = ~i_clk;

    always @(negedge i_clk) begin
        i_m_tready <= ($urandom_range(99) >= stall_pct);
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_m_tvalid && i_m_tready) sb.check_result(o_m_tdata, o_m_tlast);
    end

    // no transaction on either side for too long
    always @(posedge i_clk) begin
        if ((i_s_tvalid && o_s_tready) || (o_m_tvalid && i_m_tready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("watchdog: no transaction for %0d cycles", IDLE_LIMIT);
            $display("symmetric_band_toeplitz_filter_core_tb NOT OK");
            $finish;
        end
    end

    task automatic set_idling(input int mode);
        case (mode)
            0: begin send_idle_pct = 0;  stall_pct = 0;  end
            1: begin send_idle_pct = 86; stall_pct = 0;  end
            2: begin send_idle_pct = 0;  stall_pct = 86; end
            default: begin send_idle_pct = 38; stall_pct = 38; end
        endcase
    endtask

    task automatic write_reg(input logic [CFG_IDX_BITS-1:0] idx,
                             input logic [CFG_DATA_BITS-1:0] data);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        sb.set_reg(idx, data);
        @(negedge i_clk);
    endtask

    task automatic configure(input logic [BAND_REG_BITS-1:0] band,
                             input logic [CFG_DATA_BITS-1:0] lo,
                             input logic [CFG_DATA_BITS-1:0] hi);
        write_reg(sbtf_pkg::CFG_BAND, CFG_DATA_BITS'(band));
        write_reg(sbtf_pkg::CFG_COEF_LO, lo);
        write_reg(sbtf_pkg::CFG_COEF_HI, hi);
        i_cfg_we <= 1'b0;
    endtask

    // called and returns at a falling edge
    task automatic send_sample(input logic [15:0] smp, input logic last);
        while ($urandom_range(99) < send_idle_pct) begin
            i_s_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= smp;
        i_s_tlast  <= last;
        do @(posedge i_clk); while (o_s_tready !== 1'b1);
        sb.note_sample(smp, last);
        sent++;
        if (last) columns++;
        @(negedge i_clk);
    endtask

    task automatic wait_drained();
        i_s_tvalid <= 1'b0;
        while (sb.pending_sums.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    function automatic logic [15:0] pick_sample();
        case ($urandom_range(9))
            0: return 16'h7FFF;
            1: return 16'h8000;
            2: return 16'hFFFF;
            3: return 16'h0000;
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic logic [CFG_DATA_BITS-1:0] pick_pack(input int style);
        case (style)
            0: return {4{16'h7FFF}};
            1: return {4{16'h8000}};
            default: return {$urandom, $urandom};
        endcase
    endfunction

    // columns run across phase boundaries, so band changes hit live windows
    task automatic run_random_phase(input int items);
        int need;
        repeat (items) begin
            if (col_left == 0) begin
                need = 2 * sb.effective_band() - 1;
                if (need > 1 && $urandom_range(5) == 0) begin
                    col_left = $urandom_range(need - 1, 1);
                end else begin
                    col_left = need + $urandom_range(12);
                end
            end
            send_sample(pick_sample(), col_left == 1);
            col_left--;
        end
    endtask

    initial begin
        i_rst_n    = 1'b0;
        i_s_tvalid = 1'b0;
        i_s_tdata  = '0;
        i_s_tlast  = 1'b0;
        i_m_tready = 1'b0;
        i_cfg_we   = 1'b0;
        i_cfg_idx  = '0;
        i_cfg_data = '0;
        sb = new();
        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // band 3, extreme taps and samples; then a column too short for any row
        configure(4'd3, {16'h0000, 16'h8000, 16'h7FFF, 16'h8000},
                  {16'hFFFF, 16'h0001, 16'h7FFF, 16'h8000});
        send_sample(16'h7FFF, 1'b0);
        send_sample(16'h8000, 1'b0);
        send_sample(16'h8000, 1'b0);
        send_sample(16'h7FFF, 1'b0);
        send_sample(16'hFFFF, 1'b1);
        send_sample(16'h0001, 1'b0);
        send_sample(16'h8000, 1'b1);
        wait_drained();

        // full band, largest possible sum
        configure(4'd8, {4{16'h8000}}, {4{16'h8000}});
        repeat (14) send_sample(16'h8000, 1'b0);
        send_sample(16'h8000, 1'b1);
        wait_drained();

        // band zero acts as diagonal only
        configure(4'd0, {4{16'h8000}}, {4{16'h7FFF}});
        send_sample(16'h7FFF, 1'b1);
        wait_drained();

        for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
            set_idling(ph % 4);
            configure(BAND_REG_BITS'((ph < 6) ? BAND_PLAN[ph] : $urandom_range(15)),
                      pick_pack(ph % 3), pick_pack((ph + 1) % 3));
            run_random_phase(PHASE_ITEMS);
            wait_drained();
        end

        $display("Sent %0d samples in %0d closed columns; %0d band sums checked, %0d last-marked",
                 sent, columns, sb.checked, sb.last_marks);
        $display("Band settings 0 to 15, extreme and random taps, four idling mixes");
        if (sb.mismatches == 0 && sb.pending_sums.size() == 0) begin
            $display("symmetric_band_toeplitz_filter_core_tb OK");
        end else begin
            $display("%0d mismatches, %0d band sums outstanding",
                     sb.mismatches, sb.pending_sums.size());
            $display("symmetric_band_toeplitz_filter_core_tb NOT OK");
        end
        $finish;
    end

endmodule

// File: filelist.f
rtl/sbtf_pkg.sv
rtl/sbtf_cell.sv
rtl/symmetric_band_toeplitz_filter_core.sv
tb/symmetric_band_toeplitz_filter_core_tb.sv
